@@ src/lsp_pkg.sv @@
// Shared constants, types and helpers for the lidar scan packet parser.
// No dependencies; imported by the top level and the checker.
package lsp_pkg;

   localparam int FrameBytes = 60;
   localparam int AddrWidth  = $clog2(FrameBytes);

   typedef logic [AddrWidth-1:0] addr_type;

   localparam logic [7:0]  HdrFirst    = 8'h55;
   localparam logic [7:0]  HdrSecond   = 8'hAA;
   localparam logic [7:0]  ScanType    = 8'h23;
   localparam logic [15:0] AngleOffset = 16'h2000;
   localparam logic signed [17:0] FullTurn = 18'sd23040;

   // distance / 10 == (distance * 52429) >> 19 for every 14-bit distance
   localparam logic [15:0] DistRecip = 16'd52429;
   localparam int          DistShift = 19;

   localparam addr_type AddrType    = AddrWidth'(2);
   localparam addr_type AddrCount   = AddrWidth'(3);
   localparam addr_type AddrStartLo = AddrWidth'(6);
   localparam addr_type AddrStartHi = AddrWidth'(7);
   localparam addr_type AddrEndLo   = AddrWidth'(56);
   localparam addr_type AddrEndHi   = AddrWidth'(57);
   localparam addr_type AddrSample0 = AddrWidth'(8);

   localparam logic [2:0] FetchLen = 3'd6;
   localparam logic [4:0] DivSteps = 5'd24;

   // header bytes are fetched in this order: type, count, start lo/hi, end lo/hi
   function automatic addr_type fetch_addr(input logic [2:0] n);
      addr_type a;
      unique case (n)
         3'd0:    a = AddrType;
         3'd1:    a = AddrCount;
         3'd2:    a = AddrStartLo;
         3'd3:    a = AddrStartHi;
         3'd4:    a = AddrEndLo;
         3'd5:    a = AddrEndHi;
         default: a = AddrType;
      endcase
      return a;
   endfunction

endpackage

@@ src/lsp_channels.sv @@
// Valid/ready channel interfaces for received bytes and parsed samples.
interface lsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        frame_angle;
   logic signed [24:0] angle_step;
   logic [3:0]         sample_index;
   logic [10:0]        distance;
   logic [1:0]         sample_flags;
   logic [7:0]         strength;
   logic [4:0]         sample_count;
   logic               packet_ok;
   logic               last;

   modport source (output valid, output frame_angle, output angle_step, output sample_index,
                   output distance, output sample_flags, output strength,
                   output sample_count, output packet_ok, output last, input ready);
   modport sink   (input valid, input frame_angle, input angle_step, input sample_index,
                   input distance, input sample_flags, input strength,
                   input sample_count, input packet_ok, input last, output ready);
endinterface

@@ src/lidar_scan_packet_parser.sv @@
// Lidar scan packet parser: header hunt, frame capture into a 60-byte RAM, frame parse.
// Depends on lsp_pkg and the channel interfaces in lsp_channels.sv.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    rx_byte, one byte per item
//   rsp_ch   out  valid/ready    one sample per item, last marks the frame's final one
//
// Bytes are taken one per cycle while collecting. The closing byte of a frame starts
// the parse, during which req_ch.ready is low: header reads through the frame RAM's
// single read port, a setup step, the bit-serial step divider and its sign step
// (skipped for counts below 2), then per sample the 3 RAM reads, multiply and load;
// a load waits while the output register still holds an unaccepted item.
// The final result waits in the output register while new bytes are taken.
// Reset is synchronous; it clears control only, the frame RAM keeps its contents.
module lidar_scan_packet_parser
   import lsp_pkg::*;
#(
   parameter int MAX_SAMPLES = 16
) (
   input  logic         clock,
   input  logic         reset,
   lsp_req_if.sink      req_ch,
   lsp_rsp_if.source    rsp_ch
);

   localparam logic [4:0] MaxCnt = 5'(MAX_SAMPLES);

   typedef enum logic [2:0] {
      ST_COLLECT, ST_FETCH, ST_CALC, ST_DIV, ST_SIGN, ST_SREAD, ST_MUL, ST_EMIT
   } state_type;

   state_type state_ff;

   // frame RAM
   logic [7:0] frame_mem [FrameBytes];
   logic       wr_en;
   addr_type   wr_addr;
   addr_type   rd_addr;
   logic [7:0] rd_data_ff;

   // collection
   logic       in_frame_ff;
   logic       saw_hdr_ff;
   addr_type   pos_ff;
   logic       accept;

   // header
   logic [2:0] fetch_cnt_ff;
   logic [7:0] hdr_ff [6];
   logic       pkt_ok_ff;
   logic [4:0] count_ff;
   logic [15:0] start_ff;
   logic        neg_ff;

   // divider
   logic [3:0]  divisor_ff;
   logic [23:0] dvd_ff;
   logic [3:0]  rem_ff;
   logic [4:0]  div_cnt_ff;
   logic [4:0]  trial;
   logic        trial_ge;
   logic signed [24:0] step_ff;

   // sample path
   logic [3:0]  idx_ff;
   addr_type    samp_addr_ff;
   logic [1:0]  sub_ff;
   logic [7:0]  lo_ff;
   logic [7:0]  hi_ff;
   logic [7:0]  str_ff;
   logic [29:0] prod_ff;
   logic        is_last;

   // parse setup values
   logic [15:0]        start_c;
   logic [15:0]        end_c;
   logic signed [17:0] span_c;
   logic [15:0]        mag_c;
   logic [4:0]         cnt_c;

   // output register
   logic               rsp_valid_ff;
   logic [15:0]        rsp_start_ff;
   logic signed [24:0] rsp_step_ff;
   logic [3:0]         rsp_index_ff;
   logic [10:0]        rsp_dist_ff;
   logic [1:0]         rsp_flags_ff;
   logic [7:0]         rsp_str_ff;
   logic [4:0]         rsp_count_ff;
   logic               rsp_ok_ff;
   logic               rsp_last_ff;
   logic               out_free;

   assign req_ch.ready = (state_ff == ST_COLLECT);
   assign accept       = req_ch.valid && req_ch.ready;

   // header bytes 0 and 1 are never parsed, so the header pair is not stored
   assign wr_en   = accept && in_frame_ff;
   assign wr_addr = pos_ff;

   always_comb begin
      rd_addr = AddrType;
      if (state_ff == ST_FETCH && fetch_cnt_ff < FetchLen) begin
         rd_addr = fetch_addr(fetch_cnt_ff);
      end else if (state_ff == ST_SREAD) begin
         rd_addr = samp_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= req_ch.rx_byte;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   // hdr_ff after fetch: type, count, start lo, start hi, end lo, end hi
   always_comb begin
      start_c = {1'b0, hdr_ff[3][6:0], hdr_ff[2]} - AngleOffset;
      end_c   = {1'b0, hdr_ff[5][6:0], hdr_ff[4]} - AngleOffset;
      if (end_c >= start_c) begin
         span_c = $signed({2'b00, end_c}) - $signed({2'b00, start_c});
      end else begin
         span_c = FullTurn - $signed({2'b00, start_c}) + $signed({2'b00, end_c});
      end
      mag_c = span_c[17] ? 16'(-span_c) : span_c[15:0];
      cnt_c = (hdr_ff[1] > {3'b000, MaxCnt}) ? MaxCnt : hdr_ff[1][4:0];
   end

   assign trial    = {rem_ff, dvd_ff[23]};
   assign trial_ge = trial >= {1'b0, divisor_ff};
   assign is_last  = ({1'b0, idx_ff} + 5'd1) == count_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         in_frame_ff  <= 1'b0;
         saw_hdr_ff   <= 1'b0;
         pos_ff       <= '0;
         fetch_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_EMIT drives valid itself whenever the register is free
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_COLLECT: begin
               if (accept) begin
                  if (!in_frame_ff) begin
                     if (saw_hdr_ff && req_ch.rx_byte == HdrSecond) begin
                        in_frame_ff <= 1'b1;
                        pos_ff      <= AddrWidth'(2);
                        saw_hdr_ff  <= 1'b0;
                     end else begin
                        saw_hdr_ff <= (req_ch.rx_byte == HdrFirst);
                     end
                  end else if (pos_ff == AddrWidth'(FrameBytes - 1)) begin
                     in_frame_ff  <= 1'b0;
                     pos_ff       <= '0;
                     saw_hdr_ff   <= 1'b0;
                     fetch_cnt_ff <= '0;
                     state_ff     <= ST_FETCH;
                  end else begin
                     pos_ff <= pos_ff + AddrWidth'(1);
                  end
               end
            end
            ST_FETCH: begin
               // read data is registered and arrives in the cycle after its address
               if (fetch_cnt_ff != 3'd0) begin
                  for (int i = 0; i < 5; i++) begin
                     hdr_ff[i] <= hdr_ff[i+1];
                  end
                  hdr_ff[5] <= rd_data_ff;
               end
               fetch_cnt_ff <= fetch_cnt_ff + 3'd1;
               if (fetch_cnt_ff == FetchLen) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               pkt_ok_ff    <= (hdr_ff[0] == ScanType);
               count_ff     <= cnt_c;
               start_ff     <= start_c;
               neg_ff       <= span_c[17];
               dvd_ff       <= {mag_c, 8'h00};
               divisor_ff   <= 4'(cnt_c - 5'd1);
               rem_ff       <= '0;
               div_cnt_ff   <= '0;
               step_ff      <= '0;
               idx_ff       <= '0;
               samp_addr_ff <= AddrSample0;
               sub_ff       <= '0;
               if (hdr_ff[0] != ScanType) begin
                  state_ff <= ST_EMIT;
               end else if (cnt_c == 5'd0) begin
                  state_ff <= ST_COLLECT;
               end else if (cnt_c == 5'd1) begin
                  state_ff <= ST_SREAD;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit per cycle
               rem_ff     <= trial_ge ? 4'(trial - {1'b0, divisor_ff}) : trial[3:0];
               dvd_ff     <= {dvd_ff[22:0], trial_ge};
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == DivSteps - 5'd1) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               step_ff  <= neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
               state_ff <= ST_SREAD;
            end
            ST_SREAD: begin
               if (sub_ff != 2'd3) begin
                  samp_addr_ff <= samp_addr_ff + AddrWidth'(1);
               end
               case (sub_ff)
                  2'd1:    lo_ff  <= rd_data_ff;
                  2'd2:    hi_ff  <= rd_data_ff;
                  2'd3:    str_ff <= rd_data_ff;
                  default: ;
               endcase
               sub_ff <= sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= {hi_ff[5:0], lo_ff} * DistRecip;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (pkt_ok_ff) begin
                     rsp_start_ff <= start_ff;
                     rsp_step_ff  <= step_ff;
                     rsp_index_ff <= idx_ff;
                     rsp_dist_ff  <= (str_ff == 8'd0) ? 11'd0 : prod_ff[DistShift +: 11];
                     rsp_flags_ff <= hi_ff[7:6];
                     rsp_str_ff   <= str_ff;
                     rsp_count_ff <= count_ff;
                     rsp_ok_ff    <= 1'b1;
                     rsp_last_ff  <= is_last;
                     idx_ff       <= idx_ff + 4'd1;
                     sub_ff       <= '0;
                     state_ff     <= is_last ? ST_COLLECT : ST_SREAD;
                  end else begin
                     rsp_start_ff <= '0;
                     rsp_step_ff  <= '0;
                     rsp_index_ff <= '0;
                     rsp_dist_ff  <= '0;
                     rsp_flags_ff <= '0;
                     rsp_str_ff   <= '0;
                     rsp_count_ff <= '0;
                     rsp_ok_ff    <= 1'b0;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_COLLECT;
                  end
               end
            end
            default: state_ff <= ST_COLLECT;
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_angle  = rsp_start_ff;
   assign rsp_ch.angle_step   = rsp_step_ff;
   assign rsp_ch.sample_index = rsp_index_ff;
   assign rsp_ch.distance     = rsp_dist_ff;
   assign rsp_ch.sample_flags = rsp_flags_ff;
   assign rsp_ch.strength     = rsp_str_ff;
   assign rsp_ch.sample_count = rsp_count_ff;
   assign rsp_ch.packet_ok    = rsp_ok_ff;
   assign rsp_ch.last         = rsp_last_ff;

endmodule

@@ src/lsp_checker.sv @@
// Port-level checks for the lidar scan packet parser, bound to its top level.
// Depends on lsp_pkg and lidar_scan_packet_parser.
module lsp_checker
   import lsp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        rsp_frame_angle,
   input logic signed [24:0] rsp_angle_step,
   input logic [3:0]         rsp_sample_index,
   input logic [10:0]        rsp_distance,
   input logic [1:0]         rsp_sample_flags,
   input logic [7:0]         rsp_strength,
   input logic [4:0]         rsp_sample_count,
   input logic               rsp_packet_ok,
   input logic               rsp_last
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_index) && $stable(rsp_last))
      else $error("rsp item changed while stalled");

   // a rejected frame reports an item that is all zero but for last, which is set
   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_packet_ok |-> rsp_last && rsp_frame_angle == 16'd0
         && rsp_angle_step == 25'sd0 && rsp_sample_index == 4'd0 && rsp_distance == 11'd0
         && rsp_sample_flags == 2'd0 && rsp_strength == 8'd0 && rsp_sample_count == 5'd0)
      else $error("rejected frame item not zero");

   // last marks exactly the final sample of the count
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_ok |-> rsp_sample_count != 5'd0
         && ({1'b0, rsp_sample_index} < rsp_sample_count)
         && (rsp_last == (({1'b0, rsp_sample_index} + 5'd1) == rsp_sample_count)))
      else $error("sample index or last inconsistent with count");

   // no bytes are taken while a frame is still being emitted
   a_no_req_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("byte taken while frame results pending");

endmodule

bind lidar_scan_packet_parser lsp_checker u_lsp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_frame_angle  (rsp_ch.frame_angle),
   .rsp_angle_step   (rsp_ch.angle_step),
   .rsp_sample_index (rsp_ch.sample_index),
   .rsp_distance     (rsp_ch.distance),
   .rsp_sample_flags (rsp_ch.sample_flags),
   .rsp_strength     (rsp_ch.strength),
   .rsp_sample_count (rsp_ch.sample_count),
   .rsp_packet_ok    (rsp_ch.packet_ok),
   .rsp_last         (rsp_ch.last)
);
